// ===== rtl/lpacl_pkg.sv =====
`timescale 1ns / 1ps

package lpacl_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int FULL_ADDR_W = 2 * ADDR_W;
    localparam int PFX_W       = 8;
    localparam int TAG_W       = 16;

    localparam logic [PFX_W-1:0] IPV4_MAX_PREFIX = PFX_W'(32);
    localparam logic [PFX_W-1:0] IPV6_MAX_PREFIX = PFX_W'(128);

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_LKP,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PFX_W-1:0]  prefix;
        logic              family;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage

// ===== rtl/lpacl_entry_mem.sv =====
`timescale 1ns / 1ps

module lpacl_entry_mem (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [lpacl_pkg::IDX_W-1:0]   i_wr_addr,
    input  lpacl_pkg::t_entry             i_wr_data,
    input  logic                          i_rd_en,
    input  logic [lpacl_pkg::IDX_W-1:0]   i_rd_addr,
    output lpacl_pkg::t_entry             o_rd_data
);

    lpacl_pkg::t_entry r_mem [lpacl_pkg::TABLE_DEPTH];
    lpacl_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lpacl_prefix_cmp.sv =====
`timescale 1ns / 1ps

module lpacl_prefix_cmp (
    input  lpacl_pkg::t_entry                 i_entry,
    input  logic                              i_is_ipv6,
    input  logic [lpacl_pkg::ADDR_W-1:0]      i_addr_high,
    input  logic [lpacl_pkg::ADDR_W-1:0]      i_addr_low,
    output logic                              o_match
);

    logic [lpacl_pkg::FULL_ADDR_W-1:0] mask;
    logic [lpacl_pkg::FULL_ADDR_W-1:0] diff;

    // Bit k counted from the most significant end takes part when k is below the prefix.
    always_comb begin
        for (int k = 0; k < lpacl_pkg::FULL_ADDR_W; k++) begin
            mask[lpacl_pkg::FULL_ADDR_W-1-k] = (lpacl_pkg::PFX_W'(k) < i_entry.prefix);
        end
    end

    assign diff    = ({i_entry.addr_high, i_entry.addr_low} ^ {i_addr_high, i_addr_low}) & mask;
    assign o_match = (i_entry.family == i_is_ipv6) && (diff == '0);

endmodule

// ===== rtl/longest_prefix_acl_table.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                    Payload
// in       to block   i_in_valid / o_in_ready      i_operation, i_is_ipv6, i_address_high,
//                                                  i_address_low, i_prefix_length, i_value_tag
// out      from block o_out_valid / i_out_ready    o_status, o_hit, o_match_tag, o_match_prefix
//
// One transaction is worked on at a time; the entry memory has one read and one write port.
// An insert walks from the tail, shifting one entry per cycle, and a lookup walks from the head;
// a clear, a full-table insert, an unused code or a lookup in an empty table loads its result
// without a walk.
// Ready returns in the same cycle as o_out_valid rises for the loaded result, and the load waits while an earlier
// result still sits unclaimed in the output register. Reset empties the table at once.

module longest_prefix_acl_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic                              i_is_ipv6,
    input  logic [lpacl_pkg::ADDR_W-1:0]      i_address_high,
    input  logic [lpacl_pkg::ADDR_W-1:0]      i_address_low,
    input  logic [lpacl_pkg::PFX_W-1:0]       i_prefix_length,
    input  logic [lpacl_pkg::TAG_W-1:0]       i_value_tag,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_status,
    output logic                              o_hit,
    output logic [lpacl_pkg::TAG_W-1:0]       o_match_tag,
    output logic [lpacl_pkg::PFX_W-1:0]       o_match_prefix
);

    localparam int IDX_W = lpacl_pkg::IDX_W;
    localparam int CNT_W = lpacl_pkg::CNT_W;
    localparam int PFX_W = lpacl_pkg::PFX_W;
    localparam int TAG_W = lpacl_pkg::TAG_W;

    lpacl_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_rd_more, n_rd_more;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0]  r_put_idx, n_put_idx;
    logic [IDX_W-1:0]  r_last, n_last;

    logic              r_res_status, n_res_status;
    logic              r_res_hit, n_res_hit;
    logic [TAG_W-1:0]  r_res_tag, n_res_tag;
    logic [PFX_W-1:0]  r_res_prefix, n_res_prefix;

    logic              r_out_valid;
    logic              r_out_status;
    logic              r_out_hit;
    logic [TAG_W-1:0]  r_out_tag;
    logic [PFX_W-1:0]  r_out_prefix;

    logic                            r_fam;
    logic [lpacl_pkg::ADDR_W-1:0]    r_addr_high;
    logic [lpacl_pkg::ADDR_W-1:0]    r_addr_low;
    logic [PFX_W-1:0]                r_pfx;
    logic [TAG_W-1:0]                r_tag;

    logic              in_acc;
    logic              load_out;
    logic [PFX_W-1:0]  pfx_limit;
    logic [PFX_W-1:0]  pfx_clamped;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    lpacl_pkg::t_entry wr_data;
    lpacl_pkg::t_entry new_entry;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    lpacl_pkg::t_entry rd_data;
    logic              entry_match;
    logic [CNT_W-1:0]  count_m1;

    assign o_in_ready = (r_state == lpacl_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign pfx_limit   = i_is_ipv6 ? lpacl_pkg::IPV6_MAX_PREFIX : lpacl_pkg::IPV4_MAX_PREFIX;
    assign pfx_clamped = (i_prefix_length > pfx_limit) ? pfx_limit : i_prefix_length;
    assign count_m1    = CNT_W'(r_count - 1'b1);

    assign new_entry.addr_high = r_addr_high;
    assign new_entry.addr_low  = r_addr_low;
    assign new_entry.prefix    = r_pfx;
    assign new_entry.family    = r_fam;
    assign new_entry.tag       = r_tag;

    lpacl_entry_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lpacl_prefix_cmp u_cmp (
        .i_entry     (rd_data),
        .i_is_ipv6   (r_fam),
        .i_addr_high (r_addr_high),
        .i_addr_low  (r_addr_low),
        .o_match     (entry_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpacl_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_more   <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_more   <= n_rd_more;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_put_idx    <= n_put_idx;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_hit    <= n_res_hit;
        r_res_tag    <= n_res_tag;
        r_res_prefix <= n_res_prefix;
        if (in_acc) begin
            r_fam       <= i_is_ipv6;
            r_addr_high <= i_address_high;
            r_addr_low  <= i_address_low;
            r_pfx       <= pfx_clamped;
            r_tag       <= i_value_tag;
        end
    end

    // Insert walks from the tail: every entry with a shorter prefix moves up by one slot,
    // and the new entry lands just above the first one that is at least as long.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_rd_more    = r_rd_more;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_valid  = 1'b0;
        n_put_idx    = r_put_idx;
        n_last       = r_last;
        n_res_status = r_res_status;
        n_res_hit    = r_res_hit;
        n_res_tag    = r_res_tag;
        n_res_prefix = r_res_prefix;
        wr_en        = 1'b0;
        wr_addr      = r_put_idx;
        wr_data      = new_entry;
        rd_en        = 1'b0;
        rd_addr      = r_rd_idx;
        load_out     = 1'b0;

        unique case (r_state)
            lpacl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_res_status = lpacl_pkg::STATUS_OK;
                    n_res_hit    = 1'b0;
                    n_res_tag    = '0;
                    n_res_prefix = '0;
                    n_state      = lpacl_pkg::S_PUSH;
                    unique case (lpacl_pkg::t_op'(i_operation))
                        lpacl_pkg::OP_INSERT: begin
                            if (r_count == CNT_W'(lpacl_pkg::TABLE_DEPTH)) begin
                                n_res_status = lpacl_pkg::STATUS_FULL;
                            end else if (r_count == '0) begin
                                n_put_idx = '0;
                                n_state   = lpacl_pkg::S_INS_PUT;
                            end else begin
                                n_rd_idx  = count_m1[IDX_W-1:0];
                                n_rd_more = 1'b1;
                                n_state   = lpacl_pkg::S_INS;
                            end
                        end
                        lpacl_pkg::OP_LOOKUP: begin
                            if (r_count != '0) begin
                                n_rd_idx  = '0;
                                n_last    = count_m1[IDX_W-1:0];
                                n_rd_more = 1'b1;
                                n_state   = lpacl_pkg::S_LKP;
                            end
                        end
                        lpacl_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end

            lpacl_pkg::S_INS: begin
                rd_en       = r_rd_more;
                n_cmp_idx   = r_rd_idx;
                n_cmp_valid = r_rd_more;
                if (r_rd_more) begin
                    if (r_rd_idx == '0) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_rd_idx = IDX_W'(r_rd_idx - 1'b1);
                    end
                end
                if (r_cmp_valid) begin
                    if (rd_data.prefix < r_pfx) begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(r_cmp_idx + 1'b1);
                        wr_data = rd_data;
                        if (r_cmp_idx == '0) begin
                            n_put_idx = '0;
                            n_state   = lpacl_pkg::S_INS_PUT;
                        end
                    end else begin
                        n_put_idx = IDX_W'(r_cmp_idx + 1'b1);
                        n_state   = lpacl_pkg::S_INS_PUT;
                    end
                end
            end

            lpacl_pkg::S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_put_idx;
                wr_data = new_entry;
                n_count = CNT_W'(r_count + 1'b1);
                n_state = lpacl_pkg::S_PUSH;
            end

            lpacl_pkg::S_LKP: begin
                rd_en       = r_rd_more;
                n_cmp_idx   = r_rd_idx;
                n_cmp_valid = r_rd_more;
                if (r_rd_more) begin
                    if (r_rd_idx == r_last) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_rd_idx = IDX_W'(r_rd_idx + 1'b1);
                    end
                end
                if (r_cmp_valid) begin
                    if (entry_match) begin
                        n_res_hit    = 1'b1;
                        n_res_tag    = rd_data.tag;
                        n_res_prefix = rd_data.prefix;
                        n_state      = lpacl_pkg::S_PUSH;
                    end else if (r_cmp_idx == r_last) begin
                        n_state = lpacl_pkg::S_PUSH;
                    end
                end
            end

            lpacl_pkg::S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = lpacl_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lpacl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_hit    <= r_res_hit;
            r_out_tag    <= r_res_tag;
            r_out_prefix <= r_res_prefix;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_hit          = r_out_hit;
    assign o_match_tag    = r_out_tag;
    assign o_match_prefix = r_out_prefix;

endmodule
